// ===== design/iee_pkg.sv =====
// Package: shared types and codes for the infix expression evaluator.
`default_nettype none
package iee_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  // Operator codes held on the operator stack
  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_POW    = 3'd5,
    OP_OTHER  = 3'd6
  } op_code_t;

  // Command kinds from the front part to the back part
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_OPER   = 3'd1,
    CMD_LPAREN = 3'd2,
    CMD_RPAREN = 3'd3
  } cmd_kind_t;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DIV = 2'd1;
  localparam logic [1:0] STATUS_BAD = 2'd2;

  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  function automatic logic [1:0] op_rank(input logic [2:0] code);
    case (code)
      OP_ADD, OP_SUB: op_rank = 2'd1;
      OP_MUL, OP_DIV: op_rank = 2'd2;
      OP_POW:         op_rank = 2'd3;
      default:        op_rank = 2'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== design/infix_expression_evaluator.sv =====
// Top level: infix expression evaluator (front, command queue, back).
//
//  channel | direction | payload     | handshake
//  in      | input     | in_item_t   | in_valid / in_stall
//  out     | output    | out_item_t  | out_valid / out_stall
//
// The front takes a character per cycle unless the queue is full; digits
// without last stay there, everything else goes through a 4-entry queue.
// The back pushes any pending number, runs the reductions on the ALU, then
// pushes an operator or drops a paren; the last character reduces out and emits.
// Reset is synchronous and clears both stacks' counts and all flags.
// A stalled result holds in its register; the front stalls when the queue fills.
`default_nettype none
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16,
  parameter int DATA_WIDTH     = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int CMDW = 3 + 3 + 1 + DATA_WIDTH + 1;

  logic                  f_valid;
  logic                  q_full;
  logic [2:0]            f_kind;
  logic [2:0]            f_op;
  logic                  f_has;
  logic [DATA_WIDTH-1:0] f_num;
  logic                  f_last;
  logic                  q_ne;
  logic                  q_pop;
  logic [CMDW-1:0]       q_data;

  iee_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cmd_valid   (f_valid),
    .cmd_full    (q_full),
    .cmd_kind    (f_kind),
    .cmd_op      (f_op),
    .cmd_has_num (f_has),
    .cmd_num     (f_num),
    .cmd_last    (f_last)
  );

  iee_queue #(.WIDTH(CMDW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data ({f_kind, f_op, f_has, f_num, f_last}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_ne),
    .pop_data  (q_data)
  );

  iee_back #(
    .VALUE_DEPTH    (VALUE_DEPTH),
    .OPERATOR_DEPTH (OPERATOR_DEPTH),
    .DATA_WIDTH     (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_ne),
    .cmd_pop     (q_pop),
    .cmd_kind    (q_data[CMDW-1 -: 3]),
    .cmd_op      (q_data[CMDW-4 -: 3]),
    .cmd_has_num (q_data[DATA_WIDTH+1]),
    .cmd_num     (q_data[DATA_WIDTH:1]),
    .cmd_last    (q_data[0]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

// ===== design/iee_front.sv =====
// Front part: digit accumulation and character classification.
`default_nettype none
module iee_front
  import iee_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       cmd_valid,
  input  wire logic                  cmd_full,
  output logic [2:0]                 cmd_kind,
  output logic [2:0]                 cmd_op,
  output logic                       cmd_has_num,
  output logic [DATA_WIDTH-1:0]      cmd_num,
  output logic                       cmd_last
);

  logic [DATA_WIDTH-1:0] number_accumulator;
  logic                  in_number;
  logic                  is_digit;
  logic                  take;
  logic [DATA_WIDTH-1:0] times_ten;

  assign is_digit  = (in_data.ch >= CH_ZERO) && (in_data.ch <= CH_NINE);
  assign in_stall  = cmd_full;
  assign take      = in_valid && !cmd_full;
  assign times_ten = (number_accumulator << 3) + (number_accumulator << 1);

  // A digit without last stays in the front; everything else becomes a command
  assign cmd_valid   = take && (!is_digit || in_data.last);
  assign cmd_last    = in_data.last;
  assign cmd_has_num = in_number || is_digit;
  assign cmd_num     = is_digit ?
      times_ten + DATA_WIDTH'(in_data.ch - CH_ZERO) : number_accumulator;

  always_comb begin
    cmd_op = OP_OTHER;
    case (in_data.ch)
      CH_ADD:  cmd_op = OP_ADD;
      CH_SUB:  cmd_op = OP_SUB;
      CH_MUL:  cmd_op = OP_MUL;
      CH_DIV:  cmd_op = OP_DIV;
      CH_POW:  cmd_op = OP_POW;
      default: cmd_op = OP_OTHER;
    endcase
    if (is_digit || in_data.ch == CH_SPACE) begin
      cmd_kind = CMD_NONE;
    end else if (in_data.ch == CH_LPAREN) begin
      cmd_kind = CMD_LPAREN;
    end else if (in_data.ch == CH_RPAREN) begin
      cmd_kind = CMD_RPAREN;
    end else begin
      cmd_kind = CMD_OPER;
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      number_accumulator <= '0;
      in_number          <= 1'b0;
    end else if (take) begin
      if (is_digit && !in_data.last) begin
        number_accumulator <= cmd_num;
        in_number          <= 1'b1;
      end else begin
        number_accumulator <= '0;
        in_number          <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> !cmd_full) else $error("command pushed into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (take && !is_digit) |=> !in_number) else $error("number not flushed");
  assert property (@(posedge clk) disable iff (rst)
    !in_number |-> number_accumulator == '0) else $error("stale accumulator");

endmodule
`default_nettype wire

// ===== design/iee_queue.sv =====
// Short command queue between the front and back parts.
`default_nettype none
module iee_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full      = (fill == (AW+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill <= (AW+1)'(DEPTH)) else $error("queue fill out of range");
  assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && not_empty)) |=> not_empty)
    else $error("push lost");
  assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !full) else $error("empty and full");

endmodule
`default_nettype wire

// ===== design/iee_alu.sv =====
// Multi-cycle arithmetic unit: add, sub, mul, divide, power.
`default_nettype none
module iee_alu
  import iee_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [2:0]            op,
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic [DATA_WIDTH-1:0] b,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      result,
  output logic                       div_zero
);

  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam int HW = (DATA_WIDTH + 1) / 2;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL0, A_MUL1, A_DIV, A_POW_M, A_POW_S
  } alu_state_t;

  alu_state_t            state;
  logic [DATA_WIDTH-1:0] x;        // multiplier / base / remainder
  logic [DATA_WIDTH-1:0] y;        // high partial product / exponent / dividend
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] mag_d;
  logic                  neg_q;
  logic [CW-1:0]         cnt;
  logic [2:0]            pow_next_st;

  // Shared wrapping multiplier split in two halves of the multiplier operand
  logic [DATA_WIDTH-1:0] mul_l;
  logic [DATA_WIDTH-1:0] mul_r;
  logic [DATA_WIDTH-1:0] part_lo;
  logic [DATA_WIDTH-1:0] part_hi;
  logic [DATA_WIDTH-1:0] part_sum;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] rem_shift;

  assign part_lo = mul_l * DATA_WIDTH'(mul_r[HW-1:0]);
  assign part_hi = (mul_l * (mul_r >> HW)) << HW;
  assign rem_shift = {x[DATA_WIDTH-2:0], y[DATA_WIDTH-1]};
  assign trial = {1'b0, rem_shift} - {1'b0, mag_d};

  always_comb begin
    mul_l = acc;
    mul_r = x;
    if (state == A_POW_S) begin
      mul_l = x;
      mul_r = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      done     <= 1'b0;
      div_zero <= 1'b0;
    end else begin
      done     <= 1'b0;
      div_zero <= 1'b0;
      case (state)
        A_IDLE: begin
          if (start) begin
            case (op)
              OP_ADD: begin
                result <= a + b;
                done   <= 1'b1;
              end
              OP_SUB: begin
                result <= a - b;
                done   <= 1'b1;
              end
              OP_MUL: begin
                acc   <= a;
                x     <= b;
                state <= A_MUL0;
              end
              OP_DIV: begin
                if (b == '0) begin
                  result   <= '0;
                  div_zero <= 1'b1;
                  done     <= 1'b1;
                end else begin
                  neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                  y     <= a[DATA_WIDTH-1] ? '0 - a : a;
                  mag_d <= b[DATA_WIDTH-1] ? '0 - b : b;
                  x     <= '0;
                  cnt   <= '0;
                  state <= A_DIV;
                end
              end
              OP_POW: begin
                if (b[DATA_WIDTH-1]) begin
                  if (a == DATA_WIDTH'(1)) begin
                    result <= DATA_WIDTH'(1);
                  end else if (a == '1) begin
                    result <= b[0] ? '1 : DATA_WIDTH'(1);
                  end else begin
                    result <= '0;
                  end
                  done <= 1'b1;
                end else begin
                  acc   <= DATA_WIDTH'(1);
                  x     <= a;
                  y     <= b;
                  cnt   <= '0;
                  state <= A_POW_M;
                end
              end
              default: begin
                result <= '0;
                done   <= 1'b1;
              end
            endcase
          end
        end
        A_MUL0: begin
          acc   <= part_lo;
          y     <= part_hi;
          state <= A_MUL1;
        end
        A_MUL1: begin
          result <= acc + y;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        // Restoring division, one quotient bit per cycle
        A_DIV: begin
          if (!trial[DATA_WIDTH]) begin
            x <= trial[DATA_WIDTH-1:0];
            y <= {y[DATA_WIDTH-2:0], 1'b1};
          end else begin
            x <= rem_shift;
            y <= {y[DATA_WIDTH-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DATA_WIDTH - 1)) begin
            state <= A_POW_S;
            pow_next_st <= 3'd1;
          end
        end
        // Square and multiply: multiply step then square step per exponent bit
        A_POW_M: begin
          if (y[0]) begin
            acc <= part_lo + part_hi;
          end
          y     <= y >> 1;
          state <= A_POW_S;
          pow_next_st <= 3'd0;
        end
        A_POW_S: begin
          if (pow_next_st == 3'd1) begin
            // division finish
            result <= neg_q ? '0 - y : y;
            done   <= 1'b1;
            state  <= A_IDLE;
          end else begin
            x   <= part_lo + part_hi;
            cnt <= cnt + 1'b1;
            if (y == '0 || cnt == CW'(DATA_WIDTH - 1)) begin
              result <= acc;
              done   <= 1'b1;
              state  <= A_IDLE;
            end else begin
              state <= A_POW_M;
            end
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (start && state == A_IDLE && (op == OP_ADD || op == OP_SUB)) |=> done)
    else $error("add/sub not single cycle");
  assert property (@(posedge clk) disable iff (rst)
    div_zero |-> done) else $error("div flag without done");
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done || $past(start)) else $error("spurious done");

endmodule
`default_nettype wire

// ===== design/iee_back.sv =====
// Back part: value and operator stacks, reduction sequencer, result register.
`default_nettype none
module iee_back
  import iee_pkg::*;
#(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16,
  parameter int DATA_WIDTH     = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_pop,
  input  wire logic [2:0]            cmd_kind,
  input  wire logic [2:0]            cmd_op,
  input  wire logic                  cmd_has_num,
  input  wire logic [DATA_WIDTH-1:0] cmd_num,
  input  wire logic                  cmd_last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  localparam int VW = $clog2(VALUE_DEPTH + 1);
  localparam int OW = $clog2(OPERATOR_DEPTH + 1);
  localparam int VA = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
  localparam int OA = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_SCAN, S_POP_B, S_POP_A, S_WAIT_A, S_ALU, S_ALU_WAIT,
    S_PUSH, S_FINISH, S_EMIT
  } back_state_t;

  back_state_t           state;
  logic [DATA_WIDTH-1:0] value_stack [VALUE_DEPTH];
  logic [2:0]            operator_stack [OPERATOR_DEPTH];
  logic [VW-1:0]         value_count;
  logic [OW-1:0]         operator_count;
  logic [1:0]            error_flags;
  logic                  finishing;
  logic [DATA_WIDTH-1:0] vrd;
  logic [2:0]            top_op;
  logic [2:0]            red_op;
  logic [DATA_WIDTH-1:0] opb;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] push_val;
  logic                  vwr_en;
  logic [VA-1:0]         vwr_addr;
  logic [VA-1:0]         vrd_addr;
  logic                  owr_en;
  logic [2:0]            owr_data;
  logic [OA-1:0]         owr_addr;
  logic                  alu_start;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;
  logic                  alu_div_zero;
  logic                  need_reduce;

  // Operator top is a small register-file read
  assign top_op = operator_stack[OA'(operator_count - 1'b1)];

  // Reduce while the incoming operator binds no tighter; at the end reduce everything
  always_comb begin
    need_reduce = 1'b0;
    if (operator_count != '0) begin
      if (finishing) begin
        need_reduce = 1'b1;
      end else begin
        case (cmd_kind)
          CMD_OPER:   need_reduce = op_rank(top_op) >= op_rank(cmd_op);
          CMD_RPAREN: need_reduce = top_op != OP_LPAREN;
          default:    need_reduce = 1'b0;
        endcase
      end
    end
  end

  // Value stack memory, registered read
  always_ff @(posedge clk) begin
    if (vwr_en) begin
      value_stack[vwr_addr] <= push_val;
    end
    vrd <= value_stack[vrd_addr];
  end

  always_ff @(posedge clk) begin
    if (owr_en) begin
      operator_stack[owr_addr] <= owr_data;
    end
  end

  assign vrd_addr = VA'(value_count - 1'b1);
  assign vwr_addr = VA'(value_count);
  assign owr_addr = OA'(operator_count);
  assign vwr_en   = (state == S_NUM || (state == S_PUSH && alu_done)) &&
                    (value_count != VW'(VALUE_DEPTH));
  assign push_val = (state == S_NUM) ? cmd_num : alu_result;
  assign alu_start = (state == S_ALU);
  assign out_valid = (state == S_EMIT);

  // Operator push once reductions for this command are done
  always_comb begin
    owr_en   = 1'b0;
    owr_data = (cmd_kind == CMD_LPAREN) ? OP_LPAREN : cmd_op;
    if (state == S_SCAN && !need_reduce && !finishing &&
        operator_count != OW'(OPERATOR_DEPTH) &&
        (cmd_kind == CMD_OPER || cmd_kind == CMD_LPAREN)) begin
      owr_en = 1'b1;
    end
  end

  // Sequencer: flush number, reduce while needed, then push or finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      value_count    <= '0;
      operator_count <= '0;
      error_flags    <= '0;
      finishing      <= 1'b0;
      cmd_pop        <= 1'b0;
    end else begin
      cmd_pop <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && !cmd_pop) begin
            state <= cmd_has_num ? S_NUM : S_SCAN;
          end
        end
        S_NUM: begin
          if (value_count == VW'(VALUE_DEPTH)) begin
            error_flags[1] <= 1'b1;
          end else begin
            value_count <= value_count + 1'b1;
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (need_reduce) begin
            red_op         <= top_op;
            operator_count <= operator_count - 1'b1;
            state          <= S_POP_B;
          end else if (finishing) begin
            state <= S_FINISH;
          end else begin
            case (cmd_kind)
              CMD_OPER, CMD_LPAREN: begin
                if (operator_count == OW'(OPERATOR_DEPTH)) begin
                  error_flags[1] <= 1'b1;
                end else begin
                  operator_count <= operator_count + 1'b1;
                end
              end
              CMD_RPAREN: begin
                if (operator_count != '0) begin
                  operator_count <= operator_count - 1'b1;
                end
              end
              default: begin
                // space or bare number: nothing to push
              end
            endcase
            if (cmd_last) begin
              finishing <= 1'b1;
              state     <= S_SCAN;
            end else begin
              state   <= S_IDLE;
              cmd_pop <= 1'b1;
            end
          end
        end
        S_POP_B: begin
          if (value_count == '0) begin
            error_flags[1] <= 1'b1;
            opb   <= '0;
            state <= S_POP_A;
          end else begin
            value_count <= value_count - 1'b1;
            state <= S_WAIT_A;
          end
        end
        S_WAIT_A: begin
          opb   <= vrd;
          state <= S_POP_A;
        end
        S_POP_A: begin
          if (value_count == '0) begin
            error_flags[1] <= 1'b1;
            opa   <= '0;
            state <= S_ALU;
          end else begin
            value_count <= value_count - 1'b1;
            state <= S_ALU_WAIT;
          end
        end
        S_ALU_WAIT: begin
          opa   <= vrd;
          state <= S_ALU;
        end
        S_ALU: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (alu_done) begin
            if (alu_div_zero) begin
              error_flags[0] <= 1'b1;
            end
            if (value_count == VW'(VALUE_DEPTH)) begin
              error_flags[1] <= 1'b1;
            end else begin
              value_count <= value_count + 1'b1;
            end
            state <= S_SCAN;
          end
        end
        S_FINISH: begin
          if (value_count == '0) begin
            out_data.value <= '0;
            error_flags[1] <= 1'b1;
          end else begin
            out_data.value <= 32'(signed'(vrd));
          end
          out_data.status <= (value_count == '0 || error_flags[1]) ? STATUS_BAD :
                             (error_flags[0] ? STATUS_DIV : STATUS_OK);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            state          <= S_IDLE;
            cmd_pop        <= 1'b1;
            value_count    <= '0;
            operator_count <= '0;
            error_flags    <= '0;
            finishing      <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  iee_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .start    (alu_start),
    .op       (red_op),
    .a        (opa),
    .b        (opb),
    .done     (alu_done),
    .result   (alu_result),
    .div_zero (alu_div_zero)
  );

  assert property (@(posedge clk) disable iff (rst)
    value_count <= VW'(VALUE_DEPTH)) else $error("value count overflow");
  assert property (@(posedge clk) disable iff (rst)
    operator_count <= OW'(OPERATOR_DEPTH)) else $error("operator count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule
`default_nettype wire

// ===== verif/iee_checker.sv =====
// Checker: watches both channels, predicts expression results and compares them.
`timescale 1ns / 100ps
`default_nettype none
module iee_checker
  import iee_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             fail_count,
  output int             pending_count
);

  localparam int VDEPTH = 16;
  localparam int ODEPTH = 16;

  // Evaluator state mirrored from the expression semantics
  logic [31:0] vals [VDEPTH];
  int          nvals;
  op_code_t    ops [ODEPTH];
  int          nops;
  logic [31:0] acc;
  logic        in_num;
  logic        div_zero;
  logic        malformed;

  out_item_t   expected_results [$];

  function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] a, logic [31:0] b);
    logic [31:0] r, base;
    r = 32'd1;
    base = a;
    if (b[31]) begin
      if (a == 32'd1) return 32'd1;
      if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    for (int i = 0; i < 32; i++) begin
      if (b[i]) r = r * base;
      base = base * base;
    end
    return r;
  endfunction

  task automatic push_val(logic [31:0] v);
    if (nvals >= VDEPTH) malformed = 1'b1;
    else begin
      vals[nvals] = v;
      nvals++;
    end
  endtask

  task automatic pop_val(output logic [31:0] v);
    if (nvals == 0) begin
      malformed = 1'b1;
      v = '0;
    end else begin
      nvals--;
      v = vals[nvals];
    end
  endtask

  task automatic push_op(op_code_t c);
    if (nops >= ODEPTH) malformed = 1'b1;
    else begin
      ops[nops] = c;
      nops++;
    end
  endtask

  task automatic reduce_top();
    logic [31:0] a, b, r;
    op_code_t c;
    nops--;
    c = ops[nops];
    pop_val(b);
    pop_val(a);
    case (c)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b == 0) begin
          div_zero = 1'b1;
          r = '0;
        end else r = signed_quotient(a, b);
      end
      OP_POW: r = int_power(a, b);
      default: r = '0;
    endcase
    push_val(r);
  endtask

  task automatic end_number();
    if (in_num) begin
      push_val(acc);
      acc = '0;
      in_num = 1'b0;
    end
  endtask

  task automatic clear_state();
    nvals = 0;
    nops = 0;
    acc = '0;
    in_num = 1'b0;
    div_zero = 1'b0;
    malformed = 1'b0;
  endtask

  // Advance the evaluator by one character; queue a result on the last one
  task automatic take_char(in_item_t it);
    op_code_t c;
    out_item_t res;
    if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
      acc = acc * 32'd10 + 32'(it.ch - CH_ZERO);
      in_num = 1'b1;
    end else begin
      end_number();
      if (it.ch == CH_SPACE) begin
      end else if (it.ch == CH_LPAREN) push_op(OP_LPAREN);
      else if (it.ch == CH_RPAREN) begin
        while (nops > 0 && ops[nops-1] != OP_LPAREN) reduce_top();
        if (nops > 0) nops--;
      end else begin
        case (it.ch)
          CH_ADD:  c = OP_ADD;
          CH_SUB:  c = OP_SUB;
          CH_MUL:  c = OP_MUL;
          CH_DIV:  c = OP_DIV;
          CH_POW:  c = OP_POW;
          default: c = OP_OTHER;
        endcase
        while (nops > 0 && op_rank(ops[nops-1]) >= op_rank(c)) reduce_top();
        push_op(c);
      end
    end
    if (it.last) begin
      end_number();
      while (nops > 0) reduce_top();
      if (nvals == 0) begin
        malformed = 1'b1;
        res.value = '0;
      end else res.value = vals[nvals-1];
      res.status = malformed ? STATUS_BAD : (div_zero ? STATUS_DIV : STATUS_OK);
      expected_results.push_back(res);
      clear_state();
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (rst) begin
      clear_state();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: value=%0d status=%0d",
                 out_data.value, out_data.status);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_data.value);
            errs++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) take_char(in_data);
      fail_count <= fail_count + errs;
    end
    pending_count <= expected_results.size();
  end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench top: drives character streams into the evaluator and gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import iee_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int chars_sent = 0;

  always #5 clk = ~clk;

  infix_expression_evaluator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  iee_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver stall, randomized per cycle
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one character and hold it until accepted; valid drops only in idle gaps
  task automatic send_char(logic [7:0] c, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{ch: c, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(4))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      3: return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // A mostly well-formed expression with random content, sometimes broken
  task automatic send_random_expr();
    int terms;
    int depth;
    int kind;
    logic [7:0] c;
    terms = $urandom_range(1, 6);
    depth = 0;
    kind = $urandom_range(9);
    for (int t = 0; t < terms; t++) begin
      if (depth < 3 && $urandom_range(3) == 0) begin
        send_char(CH_LPAREN, 1'b0);
        depth++;
      end
      for (int d = $urandom_range(1, 3); d > 0; d--) send_char(rand_digit(), 1'b0);
      if ($urandom_range(5) == 0) send_char(CH_SPACE, 1'b0);
      if (depth > 0 && $urandom_range(2) == 0) begin
        send_char(CH_RPAREN, 1'b0);
        depth--;
      end
      if (t != terms - 1) begin
        if (kind == 0) c = 8'($urandom_range(255));
        else c = rand_operator();
        send_char(c, 1'b0);
      end
    end
    if (kind == 1) send_char(8'($urandom_range(255)), 1'b1);
    else if (depth > 0) send_char(CH_RPAREN, 1'b1);
    else send_char(rand_digit(), 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  initial begin
    int phase_start;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed expressions
    send_string("1+2*3");
    send_string("(1+2)*3");
    send_string("2^3^2");
    send_string("7/0");
    send_string("-7/2");
    send_string("2147483647+1");
    send_string("99999999999");
    send_string("0^0");
    send_string("2^(0-1)");
    send_string("(0-1)^(0-3)");
    send_string("1^(0-5)");
    send_string("(0-2147483647-1)/(0-1)");
    send_string("3)+4");
    send_string("5 a 6");
    send_string("+");
    send_string(" ");
    send_string("1 2 3");
    send_string("((((((((((((((((((1");
    send_string("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
    send_string("1+(2*(3+(4*(5+(6*(7+(8*(9+(1*(2+(3*(4+(5*(6+(7*8)))))))))))))))");
    send_string("(5(");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_string("9/0*0+2");

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 29 : 76) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 29 : 76) : 0;
      phase_start = chars_sent;
      while (chars_sent < phase_start + 140) send_random_expr();
      if (ph == 1) wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase_start = chars_sent;
    fork
      begin
        hold_recv = 1'b1;
        repeat (3000) @(negedge clk);
        hold_recv = 1'b0;
      end
      begin
        while (chars_sent < phase_start + 100) send_random_expr();
        in_valid <= 1'b0;
        @(negedge clk);
      end
    join

    wait_drained();
    if (fail_count == 0) $display("infix_expression_evaluator test passed");
    else $display("infix_expression_evaluator test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("infix_expression_evaluator test failed");
    $finish;
  end

endmodule
`default_nettype wire
